/* rtl/kl_pkg.sv */
// Shared types, codes, constants and helpers of the keypad LED animation sequencer.
`timescale 1ns / 1ps
`default_nettype none
package kl_pkg;

   localparam int KEY_LEDS   = 12;
   localparam int TOTAL_LEDS = 18;

   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 10;
   localparam int COUNT_W    = 16;
   localparam int TICKS_W    = 10;

   localparam logic [2:0] PAT_IDLE    = 3'd0;
   localparam logic [2:0] PAT_ALL_ON  = 3'd1;
   localparam logic [2:0] PAT_ALL_OFF = 3'd2;
   localparam logic [2:0] PAT_TOUCH   = 3'd3;
   localparam logic [2:0] PAT_BLINK   = 3'd4;
   localparam logic [2:0] PAT_SWEEP   = 3'd5;

   localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_CURRENT_CODE = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_TOUCH_TICKS  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_BLINK_TOTAL  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_BLINK_TOGGLE = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP   = 3'd5;

   localparam logic [7:0]         RST_BRIGHTNESS   = 8'd255;
   localparam logic [7:0]         RST_CURRENT_CODE = 8'd0;
   localparam logic [TICKS_W-1:0] RST_TOUCH_TICKS  = 10'd6;
   localparam logic [TICKS_W-1:0] RST_BLINK_TOTAL  = 10'd80;
   localparam logic [TICKS_W-1:0] RST_BLINK_TOGGLE = 10'd20;
   localparam logic [TICKS_W-1:0] RST_SWEEP_STEP   = 10'd30;

   localparam logic [11:0] BITS_ALL_ON  = 12'hFFF;
   localparam logic [11:0] BITS_ALL_OFF = 12'h000;
   localparam logic [11:0] BITS_CROSS   = 12'h155;

   localparam logic WRITE_SINGLE = 1'b0;
   localparam logic WRITE_FRAME  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [4:0]  idx;
      logic        on;
      logic [11:0] frame;
   } wr_type;

   typedef struct packed {
      logic play_load;
      logic tick_start;
      logic exec;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic [1:0] exec_count;
      logic [1:0] held_count;
      logic       last;
   } status_type;

   function automatic logic [11:0] to_physical(input logic [11:0] p);
      return {p[11], p[9:0], p[10]};
   endfunction

endpackage
`default_nettype wire

/* rtl/kl_req_if.sv */
// Input item channel: valid, ready and the play or tick fields.
`timescale 1ns / 1ps
`default_nettype none
interface kl_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [2:0] pattern;
   logic [4:0] key_index;

   modport source (output valid, mode, pattern, key_index, input ready);
   modport sink (input valid, mode, pattern, key_index, output ready);
endinterface
`default_nettype wire

/* rtl/kl_rsp_if.sv */
// Result channel: valid, ready and the fields of one LED write.
`timescale 1ns / 1ps
`default_nettype none
interface kl_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_kind;
   logic [4:0]  led_index;
   logic        led_on;
   logic [11:0] frame_bits;
   logic [7:0]  pwm_level;
   logic [7:0]  drive_current;
   logic        last_write;

   modport source (output valid, write_kind, led_index, led_on, frame_bits, pwm_level,
                   drive_current, last_write, input ready);
   modport sink (input valid, write_kind, led_index, led_on, frame_bits, pwm_level,
                 drive_current, last_write, output ready);
endinterface
`default_nettype wire

/* rtl/kl_csr_if.sv */
// Configuration write channel: valid, ready, register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface kl_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/kl_mod.sv */
// Bit-serial restoring remainder unit that reports whether a count is a multiple of a period.
`timescale 1ns / 1ps
`default_nettype none
module kl_mod import kl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COUNT_W-1:0] dividend,
   input  logic [TICKS_W-1:0] divisor,
   output logic               done,
   output logic               rem_zero
);

   logic [TICKS_W-1:0] rem_ff, rem_in;
   logic [TICKS_W-1:0] dvs_ff;
   logic [COUNT_W-1:0] dvd_ff;
   logic [3:0]         step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [TICKS_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[COUNT_W-1]};

   always_comb begin
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = TICKS_W'(trial - {1'b0, dvs_ff});
      end else begin
         rem_in = trial[TICKS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == 4'd15);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dvs_ff <= (divisor == '0) ? TICKS_W'(1) : divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[COUNT_W-2:0], 1'b0};
      end
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule
`default_nettype wire

/* rtl/kl_dp.sv */
// Datapath: configuration registers, pattern state, tick evaluation and the write buffer.
`timescale 1ns / 1ps
`default_nettype none
module kl_dp import kl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [2:0]           req_pattern,
   input  logic [4:0]           req_key_index,
   input  logic                 csr_write,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data,
   output logic                 rsp_write_kind,
   output logic [4:0]           rsp_led_index,
   output logic                 rsp_led_on,
   output logic [11:0]          rsp_frame_bits,
   output logic [7:0]           rsp_pwm_level,
   output logic [7:0]           rsp_drive_current,
   output logic                 rsp_last_write
);

   logic [7:0]         bright_ff, current_ff;
   logic [TICKS_W-1:0] touch_ff, total_ff, toggle_ff, step_ff;

   logic [2:0]         active_ff, active_in;
   logic [2:0]         seen_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               phase_ff, phase_in;
   logic [3:0]         row_ff, row_in;
   logic [4:0]         prev_ff, prev_in;
   logic [4:0]         key_ff;

   wr_type             list_ff [3];
   wr_type             list_in [3];
   logic [1:0]         num_ff, num_in;
   logic [1:0]         ptr_ff;

   logic               restart;
   logic [COUNT_W-1:0] count_eff, count_inc;
   logic               phase_eff;
   logic [3:0]         row_eff, row_sel, row_next;
   logic [COUNT_W-1:0] dividend;
   logic [TICKS_W-1:0] divisor;
   logic [11:0]        sweep_shift;
   logic               div_done, rem_zero;

   assign restart   = (active_ff != seen_ff);
   assign count_eff = restart ? '0 : count_ff;
   assign phase_eff = restart ? 1'b0 : phase_ff;
   assign row_eff   = restart ? 4'd0 : row_ff;
   assign count_inc = count_eff + COUNT_W'(1);
   assign row_sel   = (count_eff == '0) ? 4'd0 : row_eff;
   assign row_next  = row_sel + 4'd3;
   assign sweep_shift = 12'(7) << row_sel;

   assign dividend = (active_ff == PAT_BLINK) ? count_inc : count_eff;
   assign divisor  = (active_ff == PAT_BLINK) ? toggle_ff : step_ff;

   kl_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.tick_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .rem_zero (rem_zero)
   );

   always_comb begin
      active_in = active_ff;
      count_in  = count_eff;
      phase_in  = phase_eff;
      row_in    = row_eff;
      prev_in   = prev_ff;
      num_in    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         list_in[i] = '0;
      end
      case (active_ff)
         PAT_ALL_ON: begin
            list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0, BITS_ALL_ON};
            num_in = num_in + 2'd1;
            active_in = PAT_IDLE;
         end
         PAT_ALL_OFF: begin
            list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0, BITS_ALL_OFF};
            num_in = num_in + 2'd1;
            active_in = PAT_IDLE;
         end
         PAT_TOUCH: begin
            if ((count_eff == '0) && (key_ff < 5'(TOTAL_LEDS))) begin
               list_in[num_in] = '{WRITE_SINGLE, key_ff, 1'b0, 12'd0};
               num_in = num_in + 2'd1;
            end
            if (key_ff != prev_ff) begin
               if (prev_ff < 5'(TOTAL_LEDS)) begin
                  list_in[num_in] = '{WRITE_SINGLE, prev_ff, 1'b1, 12'd0};
                  num_in = num_in + 2'd1;
               end
               prev_in = key_ff;
            end
            count_in = count_inc;
            if (count_inc > COUNT_W'(touch_ff)) begin
               active_in = PAT_IDLE;
               if (key_ff < 5'(KEY_LEDS)) begin
                  list_in[num_in] = '{WRITE_SINGLE, key_ff, 1'b1, 12'd0};
                  num_in = num_in + 2'd1;
               end
            end
         end
         PAT_BLINK: begin
            if (count_eff == '0) begin
               list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0, to_physical(BITS_CROSS)};
               num_in = num_in + 2'd1;
               phase_in = 1'b0;
            end
            count_in = count_inc;
            if (count_inc > COUNT_W'(total_ff)) begin
               list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0, BITS_ALL_ON};
               num_in = num_in + 2'd1;
               active_in = PAT_IDLE;
            end else if (rem_zero) begin
               phase_in = ~phase_in;
               list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0,
                                   phase_in ? BITS_ALL_OFF : to_physical(BITS_CROSS)};
               num_in = num_in + 2'd1;
            end
         end
         PAT_SWEEP: begin
            row_in = row_sel;
            if (rem_zero) begin
               list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0, to_physical(sweep_shift)};
               num_in = num_in + 2'd1;
               row_in = row_next;
               if (row_next >= 4'(KEY_LEDS)) begin
                  list_in[num_in] = '{WRITE_FRAME, 5'd0, 1'b0, BITS_ALL_ON};
                  num_in = num_in + 2'd1;
                  active_in = PAT_IDLE;
               end
            end
            count_in = count_inc;
         end
         PAT_IDLE: begin
         end
         default: begin
            active_in = PAT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff  <= RST_BRIGHTNESS;
         current_ff <= RST_CURRENT_CODE;
         touch_ff   <= RST_TOUCH_TICKS;
         total_ff   <= RST_BLINK_TOTAL;
         toggle_ff  <= RST_BLINK_TOGGLE;
         step_ff    <= RST_SWEEP_STEP;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BRIGHTNESS:   bright_ff  <= csr_data[7:0];
            REG_CURRENT_CODE: current_ff <= csr_data[7:0];
            REG_TOUCH_TICKS:  touch_ff   <= csr_data;
            REG_BLINK_TOTAL:  total_ff   <= csr_data;
            REG_BLINK_TOGGLE: toggle_ff  <= csr_data;
            REG_SWEEP_STEP:   step_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= PAT_ALL_ON;
         seen_ff   <= PAT_IDLE;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
         row_ff    <= '0;
         prev_ff   <= '0;
         num_ff    <= '0;
         ptr_ff    <= '0;
      end else begin
         if (cmd.play_load) begin
            active_ff <= req_pattern;
         end
         if (cmd.exec) begin
            active_ff <= active_in;
            seen_ff   <= active_ff;
            count_ff  <= count_in;
            phase_ff  <= phase_in;
            row_ff    <= row_in;
            prev_ff   <= prev_in;
            num_ff    <= num_in;
            ptr_ff    <= '0;
         end
         if (cmd.advance) begin
            ptr_ff <= ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         key_ff <= req_key_index;
      end
      if (cmd.exec) begin
         list_ff <= list_in;
      end
   end

   assign status.div_done   = div_done;
   assign status.exec_count = num_in;
   assign status.held_count = num_ff;
   assign status.last       = (ptr_ff == (num_ff - 2'd1));

   assign rsp_write_kind    = list_ff[ptr_ff].kind;
   assign rsp_led_index     = list_ff[ptr_ff].idx;
   assign rsp_led_on        = list_ff[ptr_ff].on;
   assign rsp_frame_bits    = list_ff[ptr_ff].frame;
   assign rsp_pwm_level     = bright_ff;
   assign rsp_drive_current = current_ff;
   assign rsp_last_write    = status.last;

endmodule
`default_nettype wire

/* rtl/kl_ctrl.sv */
// Controller state machine: item acceptance, remainder wait, evaluation and write emission.
`timescale 1ns / 1ps
`default_nettype none
module kl_ctrl import kl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  cmd.play_load = 1'b1;
               end else begin
                  cmd.tick_start = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (status.exec_count != 2'd0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   a_emit_has_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (status.held_count != 2'd0))
      else $error("emitting with an empty write buffer");

   a_done_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIV))
      else $error("remainder unit finished outside the wait state");

   a_tick_starts_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_start |=> (state_ff == ST_DIV))
      else $error("tick transfer did not enter the wait state");

   a_last_leaves_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && status.last) |=> req_ready)
      else $error("block not ready after the last write transfer");

endmodule
`default_nettype wire

/* rtl/keypad_led_animation_sequencer.sv */
// A tick is accepted, then passes through the remainder wait (ST_DIV) and evaluation (ST_EXEC) states.
// Writes then follow one per cycle while rsp is ready.
// A play transfer is accepted in the idle state and the block is ready again in the next cycle.
// The bit-serial remainder unit checks the blink and sweep periods.
// Synchronous active-high reset restores register defaults and the all-on pattern.
`timescale 1ns / 1ps
`default_nettype none
module keypad_led_animation_sequencer import kl_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   kl_req_if.sink   req_bus,
   kl_rsp_if.source rsp_bus,
   kl_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   kl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   kl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pattern       (req_bus.pattern),
      .req_key_index     (req_bus.key_index),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_write_kind    (rsp_bus.write_kind),
      .rsp_led_index     (rsp_bus.led_index),
      .rsp_led_on        (rsp_bus.led_on),
      .rsp_frame_bits    (rsp_bus.frame_bits),
      .rsp_pwm_level     (rsp_bus.pwm_level),
      .rsp_drive_current (rsp_bus.drive_current),
      .rsp_last_write    (rsp_bus.last_write)
   );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the keypad LED animation sequencer with a write scoreboard.
`timescale 1ns / 1ps
module tb_top;
   import kl_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_PERCENT  = 34;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int RANDOM_ITEMS  = 70;
   localparam int MAX_WRITES    = 3;
   localparam int REPORT_LIMIT  = 10;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_PLAY = 1'b1;

   localparam logic [2:0] PAT_SPARE_6 = 3'd6;
   localparam logic [2:0] PAT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic        kind;
      logic [4:0]  idx;
      logic        on;
      logic [11:0] frame;
      logic [7:0]  pwm;
      logic [7:0]  current;
      logic        last;
   } led_write_type;

   class led_write_scoreboard;
      led_write_type pending[$];
      led_write_type tick_writes[$];
      int          mismatch_count;
      logic [7:0]  brightness;
      logic [7:0]  current_code;
      logic [9:0]  touch_ticks;
      logic [9:0]  blink_total_ticks;
      logic [9:0]  blink_toggle_ticks;
      logic [9:0]  sweep_step_ticks;
      logic [2:0]  active_pattern;
      logic [2:0]  seen_pattern;
      logic [15:0] tick_count;
      logic        blink_phase;
      logic [3:0]  sweep_row;
      logic [4:0]  previous_key;

      function new();
         mismatch_count     = 0;
         brightness         = RST_BRIGHTNESS;
         current_code       = RST_CURRENT_CODE;
         touch_ticks        = RST_TOUCH_TICKS;
         blink_total_ticks  = RST_BLINK_TOTAL;
         blink_toggle_ticks = RST_BLINK_TOGGLE;
         sweep_step_ticks   = RST_SWEEP_STEP;
         active_pattern     = PAT_ALL_ON;
         seen_pattern       = PAT_IDLE;
         tick_count         = '0;
         blink_phase        = 1'b0;
         sweep_row          = '0;
         previous_key       = '0;
      endfunction

      function void set_register(logic [2:0] index, logic [9:0] data);
         case (index)
            REG_BRIGHTNESS:   brightness = data[7:0];
            REG_CURRENT_CODE: current_code = data[7:0];
            REG_TOUCH_TICKS:  touch_ticks = data;
            REG_BLINK_TOTAL:  blink_total_ticks = data;
            REG_BLINK_TOGGLE: blink_toggle_ticks = data;
            REG_SWEEP_STEP:   sweep_step_ticks = data;
            default: ;
         endcase
      endfunction

      function logic [11:0] led_order(logic [11:0] p);
         return ((p & 12'h3FF) << 1) | (p & 12'h800) | {11'd0, p[10]};
      endfunction

      function void add_write(logic kind, logic [4:0] idx, logic on, logic [11:0] frame);
         led_write_type w;
         if (tick_writes.size() >= MAX_WRITES) return;
         w.kind    = kind;
         w.idx     = idx;
         w.on      = on;
         w.frame   = frame;
         w.pwm     = brightness;
         w.current = current_code;
         w.last    = 1'b0;
         tick_writes.push_back(w);
      endfunction

      function void add_single(logic [4:0] idx, logic on);
         if (idx < TOTAL_LEDS) add_write(WRITE_SINGLE, idx, on, 12'h000);
      endfunction

      function void add_frame(logic [11:0] bits);
         add_write(WRITE_FRAME, 5'd0, 1'b0, led_order(bits));
      endfunction

      function void note_input(logic mode, logic [2:0] pattern, logic [4:0] key);
         logic [15:0] period;
         logic [11:0] row_bits;
         tick_writes.delete();
         if (mode == MODE_PLAY) begin
            active_pattern = pattern;
            return;
         end
         if (active_pattern != seen_pattern) begin
            seen_pattern = active_pattern;
            tick_count   = '0;
            blink_phase  = 1'b0;
            sweep_row    = '0;
         end
         case (active_pattern)
            PAT_IDLE: ;
            PAT_ALL_ON: begin
               add_frame(BITS_ALL_ON);
               active_pattern = PAT_IDLE;
            end
            PAT_ALL_OFF: begin
               add_frame(BITS_ALL_OFF);
               active_pattern = PAT_IDLE;
            end
            PAT_TOUCH: begin
               if (tick_count == 16'd0) add_single(key, 1'b0);
               if (key != previous_key) begin
                  add_single(previous_key, 1'b1);
                  previous_key = key;
               end
               tick_count = tick_count + 16'd1;
               if (tick_count > 16'(touch_ticks)) begin
                  active_pattern = PAT_IDLE;
                  if (key < KEY_LEDS) add_single(key, 1'b1);
               end
            end
            PAT_BLINK: begin
               if (tick_count == 16'd0) begin
                  add_frame(BITS_CROSS);
                  blink_phase = 1'b0;
               end
               tick_count = tick_count + 16'd1;
               period = (blink_toggle_ticks == 10'd0) ? 16'd1 : 16'(blink_toggle_ticks);
               if (tick_count > 16'(blink_total_ticks)) begin
                  add_frame(BITS_ALL_ON);
                  active_pattern = PAT_IDLE;
               end else if (tick_count % period == 16'd0) begin
                  blink_phase = ~blink_phase;
                  add_frame(blink_phase ? BITS_ALL_OFF : BITS_CROSS);
               end
            end
            PAT_SWEEP: begin
               if (tick_count == 16'd0) sweep_row = '0;
               period = (sweep_step_ticks == 10'd0) ? 16'd1 : 16'(sweep_step_ticks);
               if (tick_count % period == 16'd0) begin
                  row_bits = 12'h007 << sweep_row;
                  add_frame(row_bits);
                  sweep_row = sweep_row + 4'd3;
                  if (sweep_row >= KEY_LEDS) begin
                     add_frame(BITS_ALL_ON);
                     active_pattern = PAT_IDLE;
                  end
               end
               tick_count = tick_count + 16'd1;
            end
            default: active_pattern = PAT_IDLE;
         endcase
         if (tick_writes.size() > 0) tick_writes[tick_writes.size() - 1].last = 1'b1;
         foreach (tick_writes[i]) pending.push_back(tick_writes[i]);
      endfunction

      function void check_write(led_write_type got);
         led_write_type want;
         if (pending.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"Unexpected write: kind=%0d idx=%0d on=%0d frame=%03h",
                         " pwm=%0d cur=%0d last=%0d"},
                        got.kind, got.idx, got.on, got.frame, got.pwm, got.current, got.last);
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind || got.idx !== want.idx || got.on !== want.on ||
             got.frame !== want.frame || got.pwm !== want.pwm ||
             got.current !== want.current || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Write mismatch at %0t", $realtime);
               $display("  expected kind=%0d idx=%0d on=%0d frame=%03h pwm=%0d cur=%0d last=%0d",
                        want.kind, want.idx, want.on, want.frame, want.pwm, want.current,
                        want.last);
               $display("  actual   kind=%0d idx=%0d on=%0d frame=%03h pwm=%0d cur=%0d last=%0d",
                        got.kind, got.idx, got.on, got.frame, got.pwm, got.current, got.last);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   quiet = 1'b0;
   bit   hold_request = 1'b0;

   led_write_scoreboard sb;

   kl_req_if req_bus();
   kl_rsp_if rsp_bus();
   kl_csr_if csr_bus();

   keypad_led_animation_sequencer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic send_item(logic mode, logic [2:0] pattern, logic [4:0] key);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.pattern   <= pattern;
      req_bus.key_index <= key;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_input(mode, pattern, key);
   endtask

   task automatic write_register(logic [2:0] index, logic [9:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      sb.set_register(index, data);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count);
      int         sent;
      int         ticks;
      logic [4:0] key;
      logic [2:0] pat;
      sent = 0;
      key  = 5'($urandom_range(0, 31));
      while (sent < count) begin
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 19) == 0) pat = 3'($urandom_range(6, 7));
            else pat = 3'($urandom_range(0, 5));
            send_item(MODE_PLAY, pat, 5'($urandom));
            ticks = $urandom_range(1, 16);
            for (int t = 0; t < ticks; t++) begin
               if ($urandom_range(0, 99) < 30) begin
                  if ($urandom_range(0, 3) == 0) key = 5'($urandom_range(18, 31));
                  else key = 5'($urandom_range(0, 17));
               end
               send_item(MODE_TICK, 3'($urandom), key);
            end
            sent += ticks + 1;
         end else begin
            send_item(1'($urandom), 3'($urandom), 5'($urandom));
            sent++;
         end
      end
   endtask

   task automatic run_phase(logic [9:0] bright, logic [9:0] cur, logic [9:0] touch,
                            logic [9:0] total, logic [9:0] toggle, logic [9:0] step,
                            bit no_gaps, bit squeeze);
      quiet = no_gaps;
      write_register(REG_BRIGHTNESS, bright);
      write_register(REG_CURRENT_CODE, cur);
      write_register(REG_TOUCH_TICKS, touch);
      write_register(REG_BLINK_TOTAL, total);
      write_register(REG_BLINK_TOGGLE, toggle);
      write_register(REG_SWEEP_STEP, step);
      csr_bus.valid <= 1'b0;
      if (squeeze) hold_request = 1'b1;
      run_random(RANDOM_ITEMS);
      settle();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_write('{kind: rsp_bus.write_kind, idx: rsp_bus.led_index,
                          on: rsp_bus.led_on, frame: rsp_bus.frame_bits,
                          pwm: rsp_bus.pwm_level, current: rsp_bus.drive_current,
                          last: rsp_bus.last_write});
   end

   initial begin : rsp_receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !reset) begin
            hold_request = 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         if (reset) rsp_bus.ready <= 1'b0;
         else rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.mode      <= MODE_TICK;
      req_bus.pattern   <= PAT_IDLE;
      req_bus.key_index <= 5'd0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= REG_BRIGHTNESS;
      csr_bus.data      <= 10'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The pattern after reset is all on, so the first tick sends a full frame.
      send_item(MODE_TICK, PAT_SPARE_7, 5'd0);
      send_item(MODE_PLAY, PAT_ALL_OFF, 5'd31);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      send_item(MODE_PLAY, PAT_IDLE, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      send_item(MODE_PLAY, PAT_SPARE_6, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      send_item(MODE_PLAY, PAT_SPARE_7, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd31);
      send_item(MODE_PLAY, PAT_ALL_ON, 5'd0);
      send_item(MODE_TICK, PAT_ALL_ON, 5'd31);
      // Touch keys at or above the LED count are dropped; the last tick ends the feedback.
      send_item(MODE_PLAY, PAT_TOUCH, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd5);
      send_item(MODE_TICK, PAT_IDLE, 5'd31);
      send_item(MODE_TICK, PAT_IDLE, 5'd17);
      send_item(MODE_TICK, PAT_IDLE, 5'd18);
      send_item(MODE_TICK, PAT_IDLE, 5'd12);
      send_item(MODE_TICK, PAT_IDLE, 5'd11);
      send_item(MODE_TICK, PAT_IDLE, 5'd11);
      send_item(MODE_PLAY, PAT_BLINK, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      send_item(MODE_PLAY, PAT_SWEEP, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      send_item(MODE_TICK, PAT_IDLE, 5'd0);
      settle();

      run_phase(10'h3FF, 10'h3FF, 10'd1, 10'd3, 10'd1, 10'd1, 1'b0, 1'b0);
      // Zero period registers behave as one tick.
      run_phase(10'h000, 10'h000, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b0);
      run_phase(10'h0A5, 10'h15A, 10'd4, 10'd12, 10'd3, 10'd2, 1'b0, 1'b1);
      run_phase(10'h100, 10'h2C3, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 1'b0, 1'b0);
      run_phase(10'($urandom), 10'($urandom), 10'($urandom_range(2, 8)),
                10'($urandom_range(6, 30)), 10'($urandom_range(1, 6)),
                10'($urandom_range(1, 4)), 1'b0, 1'b0);
      run_phase(10'd255, 10'd0, 10'd6, 10'd80, 10'd20, 10'd30, 1'b0, 1'b0);

      if (sb.pending.size() != 0)
         $display("%0d expected writes never arrived", sb.pending.size());
      if (sb.mismatch_count == 0 && sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

/* keypad_led_animation_sequencer.f */
rtl/kl_pkg.sv
rtl/kl_req_if.sv
rtl/kl_rsp_if.sv
rtl/kl_csr_if.sv
rtl/kl_mod.sv
rtl/kl_dp.sv
rtl/kl_ctrl.sv
rtl/keypad_led_animation_sequencer.sv
tb/tb_top.sv
